// ===== src/vrt_pkg.sv =====
// Package with the shared widths, codes and constants of the voxel ray traversal block.
`default_nettype none
package vrt_pkg;

  localparam int unsigned COORD_W  = 16;
  localparam int unsigned AXIS_W   = 2;
  localparam int unsigned ORIGIN_W = 32;
  localparam int unsigned DIR_W    = 16;
  localparam int unsigned DIST_W   = 32;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Result codes for the axis that moved.
  localparam logic [AXIS_W-1:0] AXIS_NONE = 2'd0;
  localparam logic [AXIS_W-1:0] AXIS_X    = 2'd1;
  localparam logic [AXIS_W-1:0] AXIS_Y    = 2'd2;
  localparam logic [AXIS_W-1:0] AXIS_Z    = 2'd3;

  // Per-axis step codes.
  localparam logic [1:0] STEP_NONE = 2'd0;
  localparam logic [1:0] STEP_POS  = 2'd1;
  localparam logic [1:0] STEP_NEG  = 2'd3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ORIGIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_X    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Y    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIR_Z    = 3'd5;

  localparam logic [DIST_W-1:0] DIST_SAT = 32'hFFFF_FFFF;

  // Quotients reach 2^30 at most, so 31 bits hold them.
  localparam int unsigned QUO_W = 31;
  localparam logic [QUO_W-1:0] SPAN_DIVIDEND = 31'h4000_0000;

endpackage : vrt_pkg
`default_nettype wire

// ===== src/vrt_if.sv =====
// Handshake interfaces for the input and result channels of the voxel ray traversal block.
`default_nettype none
interface vrt_in_if;
  logic valid;
  logic ready;
  logic restart;

  modport source (output valid, output restart, input ready);
  modport sink   (input valid, input restart, output ready);
endinterface : vrt_in_if

interface vrt_out_if
  import vrt_pkg::*;
;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  voxel_x;
  logic [COORD_W-1:0]  voxel_y;
  logic [COORD_W-1:0]  voxel_z;
  logic [AXIS_W-1:0]   axis_moved;

  modport source (output valid, output voxel_x, output voxel_y, output voxel_z,
                  output axis_moved, input ready);
  modport sink   (input valid, input voxel_x, input voxel_y, input voxel_z,
                  input axis_moved, output ready);
endinterface : vrt_out_if
`default_nettype wire

// ===== src/voxel_ray_traversal_3d_core.sv =====
// Top level of the voxel ray traversal block: 3D DDA grid walk with a shared serial divider.
// A step transaction is answered in the cycle after acceptance; a restart transaction
//   takes 6 divisions, each a load step followed by 31 quotient bits.
// Throughput: one step per cycle when the consumer keeps up; no input is taken while the
//   shared divider is busy, so a restart blocks the input channel for its whole duration.
// Reset (asynchronous, active low): voxel and origin zero, all directions zero, boundary
//   distances saturated, spans zero, no result pending.
`default_nettype none
module voxel_ray_traversal_3d_core
  import vrt_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  vrt_in_if.sink                     in_i,
  vrt_out_if.source                  out_o
);

  // Sequencer states.
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LOAD = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;

  localparam logic [4:0] DIV_LAST = 5'(QUO_W - 1);

  // Configuration registers.
  logic [ORIGIN_W-1:0] origin_q [3];
  logic [DIR_W-1:0]    dir_q    [3];

  // Traversal state.
  logic [COORD_W-1:0]  cell_pos_q [3];
  logic [COORD_W-1:0]  cell_pos_d [3];
  logic [1:0]          axis_dir_q [3];
  logic [DIST_W-1:0]   nb_q       [3];
  logic [DIST_W-1:0]   span_q     [3];

  // Sequencer and divider.
  logic [1:0]        state_q, state_d;
  logic [1:0]        job_axis_q;
  logic              job_span_q;
  logic [4:0]        cnt_q;
  logic [QUO_W-1:0]  div_q, div_d;
  logic [DIR_W-1:0]  rem_q, rem_d;

  // Result channel.
  logic              out_vld_q, out_vld_d;
  logic [AXIS_W-1:0] axis_q;

  logic in_acc;
  assign in_i.ready = (state_q == ST_IDLE) && (!out_vld_q || out_o.ready);
  assign in_acc     = in_i.valid && in_i.ready;

  assign out_o.valid      = out_vld_q;
  assign out_o.voxel_x    = cell_pos_q[0];
  assign out_o.voxel_y    = cell_pos_q[1];
  assign out_o.voxel_z    = cell_pos_q[2];
  assign out_o.axis_moved = axis_q;

  // Configuration writes; indexes past the register list are ignored.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        origin_q[i] <= '0;
        dir_q[i]    <= '0;
      end
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ORIGIN_X: origin_q[0] <= cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_Y: origin_q[1] <= cfg_data_i[ORIGIN_W-1:0];
        REG_ORIGIN_Z: origin_q[2] <= cfg_data_i[ORIGIN_W-1:0];
        REG_DIR_X:    dir_q[0]    <= cfg_data_i[DIR_W-1:0];
        REG_DIR_Y:    dir_q[1]    <= cfg_data_i[DIR_W-1:0];
        REG_DIR_Z:    dir_q[2]    <= cfg_data_i[DIR_W-1:0];
        default: ;
      endcase
    end
  end

  // Step selection. An axis with no direction gets a key above every distance, then
  // x wins only when strictly below both others, y when strictly below z, else z.
  logic [DIST_W:0]     key [3];
  logic                any_move;
  logic [1:0]          sel;
  logic [DIST_W:0]     sum;
  logic [DIST_W-1:0]   nb_step;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      key[i] = {axis_dir_q[i] == STEP_NONE, nb_q[i]};
    end
    any_move = (axis_dir_q[0] != STEP_NONE) || (axis_dir_q[1] != STEP_NONE) ||
               (axis_dir_q[2] != STEP_NONE);
    if (key[0] < key[1]) begin
      sel = (key[0] < key[2]) ? 2'd0 : 2'd2;
    end else begin
      sel = (key[1] < key[2]) ? 2'd1 : 2'd2;
    end
    sum     = {1'b0, nb_q[sel]} + {1'b0, span_q[sel]};
    nb_step = sum[DIST_W] ? DIST_SAT : sum[DIST_W-1:0];
    for (int i = 0; i < 3; i++) begin
      cell_pos_d[i] = cell_pos_q[i];
    end
    if (axis_dir_q[sel] == STEP_POS) begin
      cell_pos_d[sel] = cell_pos_q[sel] + COORD_W'(1);
    end else begin
      cell_pos_d[sel] = cell_pos_q[sel] - COORD_W'(1);
    end
  end

  // Divider operands for the current job: the boundary numerator (distance to the next
  // grid line in the direction of travel) scaled by 2^14, or 2^30 for the span.
  logic [DIR_W-1:0]   job_dir;
  logic [DIR_W-1:0]   job_frac;
  logic [DIR_W-1:0]   job_mag;
  logic [DIR_W:0]     job_num;
  logic [QUO_W-1:0]   job_dividend;
  logic [DIR_W:0]     rem_sh;
  logic               rem_ge;
  logic               job_last;

  always_comb begin
    job_dir      = dir_q[job_axis_q];
    job_frac     = origin_q[job_axis_q][DIR_W-1:0];
    job_mag      = job_dir[DIR_W-1] ? (DIR_W'(0) - job_dir) : job_dir;
    job_num      = job_dir[DIR_W-1] ? {1'b0, job_frac}
                                    : (17'h1_0000 - {1'b0, job_frac});
    job_dividend = job_span_q ? SPAN_DIVIDEND : {job_num, 14'd0};
    // One restoring division step per cycle.
    rem_sh       = {rem_q, div_q[QUO_W-1]};
    rem_ge       = rem_sh >= {1'b0, job_mag};
    rem_d        = rem_ge ? DIR_W'(rem_sh - {1'b0, job_mag}) : rem_sh[DIR_W-1:0];
    div_d        = {div_q[QUO_W-2:0], rem_ge};
    job_last     = (job_axis_q == 2'd2) && job_span_q;
  end

  // A result is raised by an accepted step or by the last division of a restart, and is
  // dropped once the consumer takes it.
  always_comb begin
    out_vld_d = out_vld_q && !out_o.ready;
    if (in_acc && !in_i.restart) begin
      out_vld_d = 1'b1;
    end
    if ((state_q == ST_DIV) && (cnt_q == DIV_LAST) && job_last) begin
      out_vld_d = 1'b1;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_acc && in_i.restart) state_d = ST_LOAD;
      ST_LOAD: state_d = ST_DIV;
      ST_DIV:  if (cnt_q == DIV_LAST) state_d = job_last ? ST_IDLE : ST_LOAD;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      job_axis_q <= '0;
      job_span_q <= 1'b0;
      cnt_q      <= '0;
      div_q      <= '0;
      rem_q      <= '0;
      out_vld_q  <= 1'b0;
      axis_q     <= AXIS_NONE;
      for (int i = 0; i < 3; i++) begin
        cell_pos_q[i] <= '0;
        axis_dir_q[i] <= STEP_NONE;
        nb_q[i]       <= DIST_SAT;
        span_q[i]     <= '0;
      end
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      unique case (state_q)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_i.restart) begin
              // Floor the origin into a voxel and take the step signs now; the
              // distances follow from the divider.
              for (int i = 0; i < 3; i++) begin
                cell_pos_q[i] <= origin_q[i][ORIGIN_W-1 -: COORD_W];
                if (dir_q[i] == '0) begin
                  axis_dir_q[i] <= STEP_NONE;
                end else if (dir_q[i][DIR_W-1]) begin
                  axis_dir_q[i] <= STEP_NEG;
                end else begin
                  axis_dir_q[i] <= STEP_POS;
                end
              end
              job_axis_q <= '0;
              job_span_q <= 1'b0;
            end else begin
              if (any_move) begin
                cell_pos_q[sel] <= cell_pos_d[sel];
                nb_q[sel]       <= nb_step;
                axis_q          <= AXIS_W'(sel) + AXIS_X;
              end else begin
                axis_q <= AXIS_NONE;
              end
            end
          end
        end
        ST_LOAD: begin
          div_q <= job_dividend;
          rem_q <= '0;
          cnt_q <= '0;
        end
        ST_DIV: begin
          div_q <= div_d;
          rem_q <= rem_d;
          cnt_q <= cnt_q + 5'd1;
          if (cnt_q == DIV_LAST) begin
            // A still axis gets saturated distances whatever the divider produced.
            if (job_span_q) begin
              span_q[job_axis_q] <= (job_dir == '0) ? DIST_SAT : {1'b0, div_d};
            end else begin
              nb_q[job_axis_q]   <= (job_dir == '0) ? DIST_SAT : {1'b0, div_d};
            end
            job_span_q <= !job_span_q;
            if (job_last) begin
              axis_q     <= AXIS_NONE;
              job_axis_q <= '0;
            end else if (job_span_q) begin
              job_axis_q <= job_axis_q + 2'd1;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // No result may be presented while the divider is still working on a restart.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_IDLE) |-> !out_vld_q)
    else $error("result valid while restart in progress");

  // A step transaction always yields a result in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && !in_i.restart) |=> out_vld_q)
    else $error("step transaction produced no result");

  // A restart transaction hands the input over to the divider.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_i.restart) |=> (state_q == ST_LOAD && !in_i.ready))
    else $error("restart did not start the divider");

  // A reported x step is always on an x axis that has a direction.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && axis_q == AXIS_X) |-> (axis_dir_q[0] != STEP_NONE))
    else $error("x reported as stepped with no x direction");

endmodule : voxel_ray_traversal_3d_core
`default_nettype wire

// ===== bench/voxel_ray_traversal_3d_core_tb.sv =====
// Self-checking testbench for the voxel ray traversal core, with random stimulus and backpressure.
`default_nettype none
module voxel_ray_traversal_3d_core_tb;
  import vrt_pkg::*;

  // The run is cut off here if the block stops answering.
  localparam int unsigned LIMIT_CYCLES = 1_000_000;
  // Cycles to wait after the last result.
  localparam int unsigned SETTLE_CYCLES = 200;
  // Length of the long output stall that fills the block up.
  localparam int unsigned HOLD_CYCLES = 300;
  // Register indexes past the last register; writes to them must do nothing.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;
  localparam logic [40:0] KEY_NEVER = 41'h100_0000_0000;

  typedef struct packed {
    logic [COORD_W-1:0] vx;
    logic [COORD_W-1:0] vy;
    logic [COORD_W-1:0] vz;
    logic [AXIS_W-1:0]  axis;
  } voxel_result_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  vrt_in_if  in_if ();
  vrt_out_if out_if ();

  voxel_ray_traversal_3d_core uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_i       (in_if),
    .out_o      (out_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor copy of the registers and of the walk state.
  logic [ORIGIN_W-1:0] ray_origin [3];
  logic [DIR_W-1:0]    ray_dir [3];
  logic [COORD_W-1:0]  cell_now [3];
  logic [1:0]          step_dir [3];
  logic [DIST_W-1:0]   boundary_t [3];
  logic [DIST_W-1:0]   span_t [3];

  voxel_result_t expected_voxels [$];

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_start = 1'b0;
  int mismatch_count = 0;
  int results_checked = 0;
  int reload_count = 0;
  int step_count = 0;
  int ray_count = 0;
  int axis_hits [4] = '{0, 0, 0, 0};
  longint cycle_count = 0;

  // Reload one axis from the registers: floor the origin, take the step sign
  // and divide for the first boundary distance and the per-voxel distance.
  function automatic void load_axis(input int i);
    logic [63:0] numer;
    logic [31:0] mag;
    cell_now[i] = ray_origin[i][ORIGIN_W-1:16];
    if (ray_dir[i] == '0) begin
      step_dir[i]   = STEP_NONE;
      boundary_t[i] = DIST_SAT;
      span_t[i]     = DIST_SAT;
    end else begin
      if (ray_dir[i][DIR_W-1]) begin
        mag         = 32'h1_0000 - {16'h0, ray_dir[i]};
        step_dir[i] = STEP_NEG;
        numer       = {48'h0, ray_origin[i][15:0]};
      end else begin
        mag         = {16'h0, ray_dir[i]};
        step_dir[i] = STEP_POS;
        numer       = 64'h1_0000 - {48'h0, ray_origin[i][15:0]};
      end
      // Both quotients stay at or below 2^30, so no clamping is needed.
      boundary_t[i] = 32'((numer << 14) / mag);
      span_t[i]     = 32'((64'h1 << 30) / mag);
    end
  endfunction

  // Work out the result of one transaction and advance the predicted walk.
  function automatic voxel_result_t walk_voxel(input logic restart);
    logic [40:0]   key [3];
    int            a;
    logic [32:0]   sum;
    voxel_result_t r;
    r.axis = AXIS_NONE;
    if (restart) begin
      for (int i = 0; i < 3; i++) load_axis(i);
    end else if (step_dir[0] != STEP_NONE || step_dir[1] != STEP_NONE ||
                 step_dir[2] != STEP_NONE) begin
      // Axes that never move rank above every reachable distance.
      for (int i = 0; i < 3; i++)
        key[i] = (step_dir[i] == STEP_NONE) ? KEY_NEVER : {9'h0, boundary_t[i]};
      // Tie order: x only when strictly nearest, then y only when strictly nearer than z, else z.
      if (key[0] < key[1]) a = (key[0] < key[2]) ? 0 : 2;
      else a = (key[1] < key[2]) ? 1 : 2;
      cell_now[a] = (step_dir[a] == STEP_POS) ? cell_now[a] + 16'd1 : cell_now[a] - 16'd1;
      sum = {1'b0, boundary_t[a]} + {1'b0, span_t[a]};
      boundary_t[a] = sum[32] ? DIST_SAT : sum[31:0];
      r.axis = (a == 0) ? AXIS_X : (a == 1) ? AXIS_Y : AXIS_Z;
    end
    r.vx = cell_now[0];
    r.vy = cell_now[1];
    r.vz = cell_now[2];
    return r;
  endfunction

  function automatic logic [31:0] pick_origin();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(5))
      0: v[15:0] = '0;
      1: v[31:16] = 16'h7FFF;
      2: v[31:16] = 16'h8000;
      3: v[31:16] = 16'hFFFF;
      default: ;
    endcase
    return v;
  endfunction

  // Upper bits stay random: the block must ignore them.
  function automatic logic [31:0] pick_dir();
    logic [31:0] v;
    v = $urandom();
    case ($urandom_range(8))
      0: v[15:0] = 16'h0000;
      1: v[15:0] = 16'h0001;
      2: v[15:0] = 16'hFFFF;
      3: v[15:0] = 16'h7FFF;
      4: v[15:0] = 16'h8000;
      5: v[15:0] = 16'($urandom_range(255));
      default: ;
    endcase
    return v;
  endfunction

  // Offer one transaction, idling first at the current rate, and record the
  // expected result once the block takes it.
  task automatic send_item(input logic restart);
    voxel_result_t want;
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      in_if.restart <= 1'($urandom());
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    in_if.valid <= 1'b1;
    in_if.restart <= restart;
    do @(posedge clk_i); while (!in_if.ready);
    want = walk_voxel(restart);
    expected_voxels.push_back(want);
    axis_hits[want.axis]++;
    if (restart) reload_count++;
    else step_count++;
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic drain();
    in_if.valid <= 1'b0;
    do @(posedge clk_i); while (expected_voxels.size() != 0);
  endtask

  // Program a whole ray while the block is idle; optionally poke the spare indexes too.
  task automatic write_ray(input logic [31:0] ox, oy, oz, dx, dy, dz, input logic spare);
    logic [CFG_DATA_W-1:0] vals [6];
    vals = '{ox, oy, oz, dx, dy, dz};
    for (int i = 0; i < 6; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= REG_ORIGIN_X + CFG_IDX_W'(i);
      cfg_data_i <= vals[i];
      if (i < 3) ray_origin[i] = vals[i];
      else ray_dir[i-3] = vals[i][DIR_W-1:0];
      @(posedge clk_i);
    end
    if (spare) begin
      cfg_idx_i  <= REG_SPARE_LO;
      cfg_data_i <= $urandom();
      @(posedge clk_i);
      cfg_idx_i  <= REG_SPARE_HI;
      cfg_data_i <= $urandom();
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    ray_count++;
  endtask

  task automatic check_field(input string name, input logic [COORD_W-1:0] want, got);
    if (got !== want) begin
      $error("%s: expected %0d, actual %0d", name, $signed(want), $signed(got));
      mismatch_count++;
    end
  endtask

  // Result checker: every accepted result is matched against the oldest expectation.
  always @(posedge clk_i) begin
    voxel_result_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      results_checked++;
      if (expected_voxels.size() == 0) begin
        $error("result with no transaction outstanding: voxel %0d,%0d,%0d axis %0d",
               $signed(out_if.voxel_x), $signed(out_if.voxel_y), $signed(out_if.voxel_z),
               out_if.axis_moved);
        mismatch_count++;
      end else begin
        want = expected_voxels.pop_front();
        check_field("voxel_x", want.vx, out_if.voxel_x);
        check_field("voxel_y", want.vy, out_if.voxel_y);
        check_field("voxel_z", want.vz, out_if.voxel_z);
        check_field("axis_moved", COORD_W'(want.axis), COORD_W'(out_if.axis_moved));
      end
    end
  end

  // Result consumer: random stalls, plus one long hold-off on request.
  always @(posedge clk_i) begin
    int hold_left;
    if (hold_start) begin
      hold_left  = HOLD_CYCLES;
      hold_start = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Timeout after %0d cycles, %0d results outstanding",
               cycle_count, expected_voxels.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // Straight out of reset nothing moves: steps and a reload with zero registers
  // all report voxel zero with no axis.
  task automatic test_reset_state();
    send_item(1'b0);
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
  endtask

  task automatic test_directed_rays();
    // Origin on a boundary with equal positive directions: the first boundary is a
    // whole voxel away on every axis, so the tie order alone picks z, y, x.
    drain();
    write_ray(32'h0000_0000, 32'h0000_0000, 32'h0000_0000,
              32'h0000_4000, 32'h0000_4000, 32'h0000_4000, 1'b1);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    // Extreme origins and directions that wrap the voxel coordinates.
    drain();
    write_ray(32'h7FFF_8000, 32'h8000_0000, 32'hFFFF_0000,
              32'h0000_7FFF, 32'h0000_8000, 32'h0000_4000, 1'b0);
    send_item(1'b1);
    repeat (4) send_item(1'b0);
    // Negative directions from a boundary start at distance zero; z stays put.
    drain();
    write_ray(32'h0005_0000, 32'hFFFF_0000, 32'h0003_8000,
              32'h0000_C000, 32'h0000_8000, 32'h0000_0000, 1'b0);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    // Slowest directions (with garbage in the unused upper bits) saturate both
    // moving axes, after which the tie order chooses among saturated distances.
    drain();
    write_ray(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF,
              32'hABCD_0001, 32'h1234_0001, 32'hFFFF_0000, 1'b1);
    send_item(1'b1);
    repeat (7) send_item(1'b0);
  endtask

  // Random rays, each a reload followed by a run of steps; an occasional extra
  // reload in the middle of a run restarts the same ray.
  task automatic test_random_rays(input int send_pct, recv_pct, n_items);
    int sent;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    sent = 0;
    while (sent < n_items) begin
      drain();
      write_ray(pick_origin(), pick_origin(), pick_origin(),
                pick_dir(), pick_dir(), pick_dir(), $urandom_range(9) == 0);
      send_item(1'b1);
      sent++;
      repeat ($urandom_range(40, 2)) begin
        send_item($urandom_range(15) == 0);
        sent++;
      end
    end
  endtask

  // Hold the output off for a long stretch while steps keep coming, so the
  // block fills up and has to stall its input.
  task automatic test_output_stall();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    drain();
    write_ray(32'h0010_2000, 32'hFFF0_C000, 32'h0000_0001,
              32'h0000_2000, 32'h0000_E000, 32'h0000_1000, 1'b0);
    send_item(1'b1);
    hold_start = 1'b1;
    repeat (40) send_item(1'b0);
  endtask

  initial begin
    in_if.valid   = 1'b0;
    in_if.restart = 1'b0;
    out_if.ready  = 1'b0;
    for (int i = 0; i < 3; i++) begin
      ray_origin[i] = '0;
      ray_dir[i]    = '0;
      cell_now[i]   = '0;
      step_dir[i]   = STEP_NONE;
      boundary_t[i] = DIST_SAT;
      span_t[i]     = '0;
    end
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_idle_pct = 30;
    recv_idle_pct = 83;
    test_reset_state();
    test_directed_rays();
    test_random_rays(30, 83, 160);
    test_random_rays(83, 30, 160);
    test_random_rays(0, 0, 160);
    test_output_stall();

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    $display("Walked %0d rays with %0d reloads and %0d steps; %0d results checked.",
             ray_count, reload_count, step_count, results_checked);
    $display("Axes stepped: x %0d, y %0d, z %0d; results with no move %0d.",
             axis_hits[AXIS_X], axis_hits[AXIS_Y], axis_hits[AXIS_Z], axis_hits[AXIS_NONE]);
    if (mismatch_count == 0 && expected_voxels.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule : voxel_ray_traversal_3d_core_tb
`default_nettype wire

// ===== filelist.f =====
src/vrt_pkg.sv
src/vrt_if.sv
src/voxel_ray_traversal_3d_core.sv
bench/voxel_ray_traversal_3d_core_tb.sv
